### design/mts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants of the min tracking stack unit.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int VALUE_WIDTH = 32;

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  // fixed port widths
  localparam int OP_W      = 2;
  localparam int IN_W      = 32;
  localparam int OUT_W     = 32;
  localparam int COUNT_W   = 7;
  localparam int STATUS_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RD   = 1'b1
  } core_state_e;

  typedef struct packed {
    logic [OUT_W-1:0]   top_value;
    logic [OUT_W-1:0]   min_value;
    logic [COUNT_W-1:0] entry_count;
    status_e            status;
  } result_t;

endpackage

### design/mts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/mts_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_core
// Stack engine: counts and registered tops, value and minimum memories.
// ----------------------------------------------------------------------------
module mts_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [mts_pkg::OP_W-1:0] opcode_i,
  input  logic [mts_pkg::IN_W-1:0] push_value_i,
  input  logic                     room_i,
  output logic                     res_valid_o,
  output mts_pkg::result_t         res_o
);
  import mts_pkg::*;

  core_state_e state_q, state_d;

  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [CNT_W-1:0]       mcnt_q, mcnt_d;
  logic [VALUE_WIDTH-1:0] top_q, top_d;
  logic [VALUE_WIDTH-1:0] mtop_q, mtop_d;

  logic                   accept;
  logic [VALUE_WIDTH-1:0] val;
  logic                   full, empty, min_push;
  logic                   pop_go;
  status_e                status;

  logic                   val_we, min_we;
  logic [ADDR_W-1:0]      val_raddr, min_raddr;
  logic [VALUE_WIDTH-1:0] val_rdata, min_rdata;

  assign in_stall_o = (state_q != S_IDLE) || !room_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign val        = VALUE_WIDTH'(push_value_i);
  assign full       = (cnt_q == CNT_W'(STACK_DEPTH));
  assign empty      = (cnt_q == '0);
  // duplicates of the current minimum go on the minimum stack too
  assign min_push   = ((mcnt_q == '0) || (val <= mtop_q)) &&
                      (mcnt_q != CNT_W'(STACK_DEPTH));

  // datapath and result
  always_comb begin
    cnt_d       = cnt_q;
    mcnt_d      = mcnt_q;
    top_d       = top_q;
    mtop_d      = mtop_q;
    val_we      = 1'b0;
    min_we      = 1'b0;
    pop_go      = 1'b0;
    status      = STAT_DONE;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (state_q == S_RD) begin
      // new tops arrive from the memories in the cycle after the pop
      top_d             = val_rdata;
      mtop_d            = min_rdata;
      res_valid_o       = 1'b1;
      res_o.top_value   = (cnt_q != '0) ? OUT_W'(val_rdata) : '0;
      res_o.min_value   = (mcnt_q != '0) ? OUT_W'(min_rdata) : '0;
      res_o.entry_count = COUNT_W'(cnt_q);
      res_o.status      = STAT_DONE;
    end else if (accept) begin
      unique case (opcode_e'(opcode_i))
        OP_PUSH: begin
          if (full) begin
            status = STAT_FULL;
          end else begin
            val_we = 1'b1;
            cnt_d  = cnt_q + CNT_W'(1);
            top_d  = val;
            if (min_push) begin
              min_we = 1'b1;
              mcnt_d = mcnt_q + CNT_W'(1);
              mtop_d = val;
            end
          end
        end
        OP_POP: begin
          if (empty) begin
            status = STAT_EMPTY;
          end else begin
            pop_go = 1'b1;
            cnt_d  = cnt_q - CNT_W'(1);
            if ((mcnt_q != '0) && (top_q == mtop_q)) begin
              mcnt_d = mcnt_q - CNT_W'(1);
            end
          end
        end
        default: begin
          status = STAT_DONE;
        end
      endcase
      if (!pop_go) begin
        res_valid_o       = 1'b1;
        res_o.top_value   = (cnt_d != '0) ? OUT_W'(top_d) : '0;
        res_o.min_value   = (mcnt_d != '0) ? OUT_W'(mtop_d) : '0;
        res_o.entry_count = COUNT_W'(cnt_d);
        res_o.status      = status;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (pop_go) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      mcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      mcnt_q  <= mcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    mtop_q <= mtop_d;
  end

  // read the tops left after a pop: the entry below the popped value, and the minimum entry that remains
  assign val_raddr = ADDR_W'(cnt_q - CNT_W'(2));
  assign min_raddr = ADDR_W'(mcnt_d - CNT_W'(1));

  mts_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(STACK_DEPTH)
  ) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(ADDR_W'(cnt_q)),
    .wdata_i(val),
    .raddr_i(val_raddr),
    .rdata_o(val_rdata)
  );

  mts_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(STACK_DEPTH)
  ) u_min_ram (
    .clk_i  (clk_i),
    .we_i   (min_we),
    .waddr_i(ADDR_W'(mcnt_q)),
    .wdata_i(val),
    .raddr_i(min_raddr),
    .rdata_o(min_rdata)
  );

endmodule

### design/mts_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_obuf
// Two entry result buffer between the stack engine and the output channel.
// ----------------------------------------------------------------------------
module mts_obuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  mts_pkg::result_t wdata_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mts_pkg::result_t rdata_o
);
  import mts_pkg::*;

  result_t    buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q, fill_d;
  logic       rd;

  assign out_valid_o = (fill_q != 2'd0);
  assign room_o      = (fill_q != 2'd2);
  assign rd          = out_valid_o && !out_stall_i;
  assign rdata_o     = buf_q[rd_ptr_q];

  always_comb begin
    fill_d = fill_q;
    if (wr_i && !rd) begin
      fill_d = fill_q + 2'd1;
    end else if (rd && !wr_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      fill_q <= fill_d;
      if (wr_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      buf_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### design/min_tracking_stack_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_unit
// Stack of values that also reports its running minimum after every operation.
// ----------------------------------------------------------------------------
// results: push, peek and rejected operations enter the output buffer as
//   they are accepted, a pop's from the read state after the registered
//   memory read of the entry below the popped top; the read state stalls input
// throughput: 1 transaction per cycle for push and peek while buffer has room
// reset: counts and control are cleared at once, memories are not cleared and
//   no clearing pass runs, so the unit is ready in the first cycle after reset
module min_tracking_stack_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mts_pkg::OP_W-1:0]     opcode_i,
  input  logic [mts_pkg::IN_W-1:0]     push_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mts_pkg::OUT_W-1:0]    top_value_o,
  output logic [mts_pkg::OUT_W-1:0]    min_value_o,
  output logic [mts_pkg::COUNT_W-1:0]  entry_count_o,
  output logic [mts_pkg::STATUS_W-1:0] status_o
);
  import mts_pkg::*;

  logic    room;
  logic    res_valid;
  result_t res;
  result_t out_res;

  mts_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .push_value_i(push_value_i),
    .room_i      (room),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mts_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (res_valid),
    .wdata_i    (res),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .rdata_o    (out_res)
  );

  assign top_value_o   = out_res.top_value;
  assign min_value_o   = out_res.min_value;
  assign entry_count_o = out_res.entry_count;
  assign status_o      = out_res.status;

  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STAT_FULL) |->
      (entry_count_o == COUNT_W'(STACK_DEPTH)))
    else $error("full status with stack not full");

  a_empty_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STAT_EMPTY) |->
      (entry_count_o == '0 && top_value_o == '0 && min_value_o == '0))
    else $error("empty status with nonzero result fields");

  a_zero_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && entry_count_o == '0) |->
      (top_value_o == '0 && min_value_o == '0))
    else $error("empty stack reports a top or minimum");

  a_min_not_above_top : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && entry_count_o != '0) |-> (min_value_o <= top_value_o))
    else $error("minimum above top value");

endmodule

### bench/min_stack_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_stack_checker
// Follows every transaction on the input side, predicts the top, minimum,
// count and status that the stack must report for it, and compares each
// result leaving the unit with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module min_stack_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [mts_pkg::OP_W-1:0]     opcode_i,
  input  logic [mts_pkg::IN_W-1:0]     push_value_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [mts_pkg::OUT_W-1:0]    top_value_i,
  input  logic [mts_pkg::OUT_W-1:0]    min_value_i,
  input  logic [mts_pkg::COUNT_W-1:0]  entry_count_i,
  input  logic [mts_pkg::STATUS_W-1:0] status_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           checked_o,
  output int                           full_hits_o,
  output int                           empty_hits_o
);
  import mts_pkg::*;

  logic [OUT_W-1:0] value_trail [STACK_DEPTH];
  logic [OUT_W-1:0] min_trail   [STACK_DEPTH];
  int               value_depth;
  int               min_depth;
  result_t          pending_results [$];

  function automatic result_t apply_stack_op(input logic [OP_W-1:0] op,
                                             input logic [IN_W-1:0] value);
    result_t r;
    logic [OUT_W-1:0] popped;
    r.status = STAT_DONE;
    if (op == OP_PUSH) begin
      if (value_depth >= STACK_DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        value_trail[ADDR_W'(value_depth)] = value;
        value_depth++;
        // equal values are stacked too, so popping one duplicate keeps the min
        if (min_depth == 0 || value <= min_trail[ADDR_W'(min_depth-1)]) begin
          min_trail[ADDR_W'(min_depth)] = value;
          min_depth++;
        end
      end
    end else if (op == OP_POP) begin
      if (value_depth == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        popped = value_trail[ADDR_W'(value_depth-1)];
        value_depth--;
        if (min_depth > 0 && popped == min_trail[ADDR_W'(min_depth-1)]) begin
          min_depth--;
        end
      end
    end
    // peek and the unused opcode leave everything as it is
    r.top_value = '0;
    r.min_value = '0;
    if (value_depth > 0) begin
      r.top_value = value_trail[ADDR_W'(value_depth-1)];
    end
    if (min_depth > 0) begin
      r.min_value = min_trail[ADDR_W'(min_depth-1)];
    end
    r.entry_count = COUNT_W'(value_depth);
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      value_depth = 0;
      min_depth = 0;
      pending_results.delete();
      fail_count_o = 0;
      checked_o = 0;
      full_hits_o = 0;
      empty_hits_o = 0;
    end else begin
      // results first: nothing accepted at this edge can already be answered
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual top %h min %h count %0d status %0d",
                   $time, top_value_i, min_value_i, entry_count_i, status_i);
          fail_count_o++;
        end else begin
          want = pending_results.pop_front();
          checked_o++;
          compare_field("top_value", want.top_value, top_value_i);
          compare_field("min_value", want.min_value, min_value_i);
          compare_field("entry_count", OUT_W'(want.entry_count), OUT_W'(entry_count_i));
          compare_field("status", OUT_W'(want.status), OUT_W'(status_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = apply_stack_op(opcode_i, push_value_i);
        if (want.status == STAT_FULL) begin
          full_hits_o++;
        end
        if (want.status == STAT_EMPTY) begin
          empty_hits_o++;
        end
        pending_results.push_back(want);
      end
    end
    pending_o = pending_results.size();
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives push, pop and peek transactions into the min tracking stack in
// random bursts, with a directed opening and random fill, drain and mixed
// phases, while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
  import mts_pkg::*;

  localparam int               ITEM_TARGET    = 1050;
  localparam int               WATCHDOG_LIMIT = 2000;
  localparam int               LONG_HOLD      = 160;
  localparam int               SETTLE_CYCLES  = 8;
  localparam logic [OP_W-1:0]  OP_UNUSED      = 2'd3;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_MIXED
  } mix_e;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [OP_W-1:0]     opcode_i;
  logic [IN_W-1:0]     push_value_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [OUT_W-1:0]    top_value_o;
  logic [OUT_W-1:0]    min_value_o;
  logic [COUNT_W-1:0]  entry_count_o;
  logic [STATUS_W-1:0] status_o;

  int fail_count;
  int pending;
  int checked;
  int full_hits;
  int empty_hits;
  int items_sent;
  int burst_left;
  int quiet_cycles;

  min_tracking_stack_unit DUT (.*);

  min_stack_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .opcode_i      (opcode_i),
    .push_value_i  (push_value_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .top_value_i   (top_value_o),
    .min_value_i   (min_value_o),
    .entry_count_i (entry_count_o),
    .status_i      (status_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .full_hits_o   (full_hits),
    .empty_hits_o  (empty_hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // small values give lots of duplicates and ties on the minimum
  function automatic logic [IN_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(9);
    if (roll < 4) begin
      return IN_W'($urandom_range(15));
    end
    if (roll < 6) begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return '1;
        2:       return 32'h8000_0000;
        default: return 32'h7fff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  task automatic offer(input logic [OP_W-1:0] op, input logic [IN_W-1:0] value);
    int idle_cycles;
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    push_value_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      idle_cycles = $urandom_range(1, 6);
      if ($urandom_range(9) == 0) begin
        idle_cycles = $urandom_range(10, 30);
      end
      in_valid_i <= 1'b0;
      repeat (idle_cycles) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  initial begin
    mix_e            mix;
    int              seg_len;
    int              roll;
    logic [OP_W-1:0] op;
    in_valid_i   = 1'b0;
    opcode_i     = OP_PEEK;
    push_value_i = '0;
    items_sent   = 0;
    burst_left   = 12;
    @(posedge rst_ni);
    @(posedge clk_i);

    // empty stack corner cases
    offer(OP_POP, 32'h0000_1234);
    offer(OP_PEEK, '1);
    offer(OP_UNUSED, 32'h5555_5555);
    // duplicate minimum and the extremes of the value range
    offer(OP_PUSH, '1);
    offer(OP_PUSH, '0);
    offer(OP_PUSH, '0);
    offer(OP_PUSH, '1);
    offer(OP_PUSH, 32'd7);
    offer(OP_PEEK, 32'haaaa_aaaa);
    offer(OP_UNUSED, '0);
    offer(OP_POP, '0);
    offer(OP_POP, '0);
    offer(OP_POP, '0);
    offer(OP_POP, '0);
    offer(OP_POP, '0);
    offer(OP_POP, '0);
    offer(OP_PUSH, 32'd10);
    offer(OP_PUSH, 32'd10);
    offer(OP_PUSH, 32'd3);
    offer(OP_PUSH, 32'd11);
    offer(OP_POP, '0);
    offer(OP_POP, '0);
    offer(OP_POP, '0);
    offer(OP_PEEK, '0);

    while (items_sent < ITEM_TARGET) begin
      mix = mix_e'($urandom_range(2));
      seg_len = $urandom_range(20, 110);
      if (seg_len > ITEM_TARGET - items_sent) begin
        seg_len = ITEM_TARGET - items_sent;
      end
      repeat (seg_len) begin
        roll = $urandom_range(99);
        case (mix)
          MIX_FILL: begin
            op = (roll < 85) ? OP_PUSH : (roll < 95) ? OP_POP : OP_PEEK;
          end
          MIX_DRAIN: begin
            op = (roll < 85) ? OP_POP : (roll < 95) ? OP_PUSH : OP_PEEK;
          end
          default: begin
            op = (roll < 45) ? OP_PUSH : (roll < 85) ? OP_POP :
                 (roll < 96) ? OP_PEEK : OP_UNUSED;
          end
        endcase
        offer(op, pick_value());
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("ran %0d stack transactions through fill, drain and mixed phases, %0d results checked",
             items_sent, checked);
    $display("refused pushes on a full stack: %0d, refused pops on an empty stack: %0d",
             full_hits, empty_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // result side: random stall patterns, one long hold to back up the input
  initial begin
    int seg;
    int seg_len;
    int pattern;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    seg = 0;
    forever begin
      if (seg == 4) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        pattern = $urandom_range(3);
        seg_len = $urandom_range(20, 150);
        repeat (seg_len) begin
          case (pattern)
            0:       out_stall_i <= 1'b0;
            1:       out_stall_i <= ($urandom_range(99) < 30);
            2:       out_stall_i <= ($urandom_range(99) < 75);
            default: out_stall_i <= ~out_stall_i;
          endcase
          @(posedge clk_i);
        end
      end
      seg++;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule

### filelist.f
design/mts_pkg.sv
design/mts_ram.sv
design/mts_core.sv
design/mts_obuf.sv
design/min_tracking_stack_unit.sv
bench/min_stack_checker.sv
bench/tb_top.sv
